// File: rtl/lsvm_pkg.sv
package lsvm_pkg;

  localparam int VOICES       = 16;
  localparam int FRAME        = 128;
  localparam int SAMPLE_WORDS = 65536;

  localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int FRAME_W = (FRAME > 1) ? $clog2(FRAME) : 1;
  localparam int MEM_AW  = $clog2(SAMPLE_WORDS);

  localparam int MIX_W = 20;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_START = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef struct packed {
    logic mem_wr;
    logic voice_ld;
    logic clear;
    logic issue;
    logic frame_adv;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage

// File: rtl/lsvm_ctrl.sv
module lsvm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        func,
  output logic              busy,
  output logic              done,
  output lsvm_pkg::cmd_t    cmd,
  input  lsvm_pkg::status_t status
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state == S_ISSUE) || (state == S_DRAIN);
  assign done   = (state == S_DONE);
  assign accept = start && !busy;

  always_comb begin
    cmd           = '0;
    cmd.mem_wr    = accept && (func == lsvm_pkg::FUNC_WRITE);
    cmd.voice_ld  = accept && (func == lsvm_pkg::FUNC_START);
    cmd.clear     = accept && (func == lsvm_pkg::FUNC_TICK);
    cmd.issue     = (state == S_ISSUE);
    cmd.frame_adv = (state == S_DRAIN);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE, S_DONE: begin
        if (accept && (func == lsvm_pkg::FUNC_TICK)) begin
          state_next = S_ISSUE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ISSUE: begin
        if (status.last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func == lsvm_pkg::FUNC_TICK)) |=> (busy && cmd.issue))
    else $error("accepted tick did not start the voice sweep");
  a_drain_done: assert property (@(posedge clk) disable iff (rst) cmd.frame_adv |=> done)
    else $error("frame update not followed by result");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(cmd.mem_wr || cmd.voice_ld || cmd.clear))
    else $error("transaction taken while busy");

endmodule

// File: rtl/lsvm_datapath.sv
module lsvm_datapath (
  input  logic              clk,
  input  logic              rst,
  input  lsvm_pkg::cmd_t    cmd,
  output lsvm_pkg::status_t status,
  input  logic [3:0]        voice,
  input  logic [15:0]       address,
  input  logic signed [15:0] sample_value,
  input  logic [15:0]       loop_start,
  input  logic [15:0]       loop_end,
  input  logic [23:0]       step,
  input  logic [15:0]       length_frames,
  output logic signed [lsvm_pkg::MIX_W-1:0] mix_sample
);

  logic signed [15:0] mem [lsvm_pkg::SAMPLE_WORDS];
  logic signed [15:0] mem_rd;
  logic               rd_valid;

  logic [15:0] voice_position    [lsvm_pkg::VOICES];
  logic [15:0] voice_phase       [lsvm_pkg::VOICES];
  logic [23:0] voice_step        [lsvm_pkg::VOICES];
  logic [15:0] voice_loop_first  [lsvm_pkg::VOICES];
  logic [15:0] voice_loop_last   [lsvm_pkg::VOICES];
  logic [15:0] voice_frames_left [lsvm_pkg::VOICES];

  logic [lsvm_pkg::VOICE_W-1:0] cnt;
  logic [lsvm_pkg::FRAME_W-1:0] frame_cnt;
  logic                         frame_wrap;

  logic [lsvm_pkg::VOICE_W-1:0] vidx;
  logic                         voice_ok;

  logic        cur_active;
  logic [24:0] phase_acc;
  logic [16:0] pos_grown;
  logic [15:0] span;
  logic [16:0] pos_next;
  logic [15:0] frames_next;

  logic signed [lsvm_pkg::MIX_W-1:0] sum;
  logic signed [lsvm_pkg::MIX_W:0]   sum_ext;
  logic signed [lsvm_pkg::MIX_W-1:0] sum_next;

  localparam logic signed [lsvm_pkg::MIX_W-1:0] MixMax = {1'b0, {(lsvm_pkg::MIX_W-1){1'b1}}};
  localparam logic signed [lsvm_pkg::MIX_W-1:0] MixMin = {1'b1, {(lsvm_pkg::MIX_W-1){1'b0}}};

  assign status.last = (cnt == lsvm_pkg::VOICE_W'(lsvm_pkg::VOICES - 1));
  assign frame_wrap  = (frame_cnt == lsvm_pkg::FRAME_W'(lsvm_pkg::FRAME - 1));
  assign vidx        = lsvm_pkg::VOICE_W'(voice);
  assign voice_ok    = (32'(voice) < lsvm_pkg::VOICES);

  assign cur_active  = (voice_frames_left[cnt] != 16'd0);
  assign phase_acc   = 25'(voice_phase[cnt]) + 25'(voice_step[cnt]);
  assign pos_grown   = 17'(voice_position[cnt]) + 17'(phase_acc[24:16]);
  assign span        = voice_loop_last[cnt] - voice_loop_first[cnt] + 16'd1;
  assign pos_next    = (pos_grown >= 17'(voice_loop_last[cnt])) ? (pos_grown - 17'(span))
                                                                : pos_grown;
  assign frames_next = frame_wrap ? (voice_frames_left[cnt] - 16'd1) : voice_frames_left[cnt];

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[lsvm_pkg::MEM_AW'(address)] <= sample_value;
    end
    if (cmd.issue) begin
      mem_rd <= mem[lsvm_pkg::MEM_AW'(voice_position[cnt])];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lsvm_pkg::VOICES; i++) begin
        voice_position[i]    <= '0;
        voice_phase[i]       <= '0;
        voice_step[i]        <= '0;
        voice_loop_first[i]  <= '0;
        voice_loop_last[i]   <= '0;
        voice_frames_left[i] <= '0;
      end
    end else if (cmd.voice_ld) begin
      if (voice_ok) begin
        voice_position[vidx]    <= address;
        voice_phase[vidx]       <= '0;
        voice_step[vidx]        <= step;
        voice_loop_first[vidx]  <= loop_start;
        voice_loop_last[vidx]   <= loop_end;
        voice_frames_left[vidx] <= length_frames;
      end
    end else if (cmd.issue && cur_active) begin
      voice_position[cnt]    <= pos_next[15:0];
      voice_phase[cnt]       <= phase_acc[15:0];
      voice_frames_left[cnt] <= frames_next;
    end
  end

  always_comb begin
    sum_ext = {sum[lsvm_pkg::MIX_W-1], sum} + (lsvm_pkg::MIX_W + 1)'(mem_rd);
    if (sum_ext[lsvm_pkg::MIX_W] != sum_ext[lsvm_pkg::MIX_W-1]) begin
      sum_next = sum_ext[lsvm_pkg::MIX_W] ? MixMin : MixMax;
    end else begin
      sum_next = sum_ext[lsvm_pkg::MIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      frame_cnt <= '0;
      rd_valid  <= 1'b0;
      sum       <= '0;
    end else begin
      rd_valid <= cmd.issue && cur_active;
      if (cmd.clear) begin
        cnt <= '0;
        sum <= '0;
      end else begin
        if (cmd.issue) begin
          cnt <= cnt + 1'b1;
        end
        if (rd_valid) begin
          sum <= sum_next;
        end
      end
      if (cmd.frame_adv) begin
        frame_cnt <= frame_wrap ? '0 : frame_cnt + 1'b1;
      end
    end
  end

  assign mix_sample = sum;

endmodule

// File: rtl/looping_sample_voice_mixer.sv
// Channel  Direction  Handshake             Payload
// item     in         start, busy           func voice address sample_value loop_start
//                                           loop_end step length_frames
// result   out        done (one-cycle)      mix_sample
//
// Sample write and voice start: busy stays low.
// Tick: busy through an issue state and a drain state, then done for one cycle;
// the issue state takes one voice per cycle through the single sample memory read port,
// and the drain state adds the last registered read and advances the frame count.
// A new item may be taken in the cycle that done is high.
// rst is synchronous: all voices silent, frame count cleared; sample memory not cleared.
// done cannot be held off; mix_sample is valid only while done is high.
module looping_sample_voice_mixer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         func,
  input  logic [3:0]                         voice,
  input  logic [15:0]                        address,
  input  logic signed [15:0]                 sample_value,
  input  logic [15:0]                        loop_start,
  input  logic [15:0]                        loop_end,
  input  logic [23:0]                        step,
  input  logic [15:0]                        length_frames,
  output logic                               done,
  output logic signed [lsvm_pkg::MIX_W-1:0]  mix_sample
);

  lsvm_pkg::cmd_t    cmd;
  lsvm_pkg::status_t status;

  lsvm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  lsvm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .voice         (voice),
    .address       (address),
    .sample_value  (sample_value),
    .loop_start    (loop_start),
    .loop_end      (loop_end),
    .step          (step),
    .length_frames (length_frames),
    .mix_sample    (mix_sample)
  );

endmodule

// File: verif/looping_sample_voice_mixer_tb.sv
`timescale 1ns / 100ps

class mix_scoreboard;
  bit [15:0] sample_word [0:65535];
  bit        written [0:65535];
  bit [15:0] position [16];
  bit [15:0] phase [16];
  bit [23:0] pitch [16];
  bit [15:0] loop_first [16];
  bit [15:0] loop_last [16];
  bit [15:0] frames_left [16];
  int        frame_ticks;
  logic signed [19:0] expected_mix [$];
  int errors, checked, writes, starts, ticks, idles, wraps, expiries;

  function void note_item(lsvm_pkg::func_t f, bit [3:0] v, bit [15:0] addr, bit [15:0] value,
                          bit [15:0] ls, bit [15:0] le, bit [23:0] st, bit [15:0] len);
    int sum;
    bit [31:0] acc, npos, span;
    case (f)
      lsvm_pkg::FUNC_WRITE: begin
        sample_word[addr] = value;
        written[addr] = 1'b1;
        writes++;
      end
      lsvm_pkg::FUNC_START: begin
        position[v] = addr;
        phase[v] = '0;
        loop_first[v] = ls;
        loop_last[v] = le;
        pitch[v] = st;
        frames_left[v] = len;
        starts++;
      end
      lsvm_pkg::FUNC_TICK: begin
        sum = 0;
        for (int k = 0; k < lsvm_pkg::VOICES; k++) begin
          if (frames_left[k] != 0) begin
            sum = sum + int'($signed(sample_word[position[k]]));
            if (sum > 524287) sum = 524287;
            if (sum < -524288) sum = -524288;
          end
        end
        for (int k = 0; k < lsvm_pkg::VOICES; k++) begin
          if (frames_left[k] != 0) begin
            acc = {16'b0, phase[k]} + {8'b0, pitch[k]};
            npos = {16'b0, position[k]} + (acc >> 16);
            phase[k] = acc[15:0];
            if (npos >= {16'b0, loop_last[k]}) begin
              span = ({16'b0, loop_last[k]} - {16'b0, loop_first[k]} + 32'd1) & 32'hFFFF;
              npos = npos - span;
              wraps++;
            end
            position[k] = npos[15:0];
          end
        end
        frame_ticks++;
        if (frame_ticks >= lsvm_pkg::FRAME) begin
          frame_ticks = 0;
          for (int k = 0; k < lsvm_pkg::VOICES; k++) begin
            if (frames_left[k] != 0) begin
              frames_left[k]--;
              if (frames_left[k] == 0) expiries++;
            end
          end
        end
        expected_mix.push_back(sum[19:0]);
        ticks++;
      end
      default: idles++;
    endcase
  endfunction

  function void check_mix(logic signed [19:0] got);
    logic signed [19:0] want;
    if (expected_mix.size() == 0) begin
      errors++;
      $display("%0t: mix_sample expected none, got %0d", $time, got);
    end else begin
      want = expected_mix.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        $display("%0t: mix_sample expected %0d, got %0d", $time, want, got);
      end
    end
  endfunction
endclass

module looping_sample_voice_mixer_tb;

  localparam int LIMIT = 1000000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               func = lsvm_pkg::FUNC_WRITE;
  logic [3:0]               voice = '0;
  logic [15:0]              address = '0;
  logic signed [15:0]       sample_value = '0;
  logic [15:0]              loop_start = '0;
  logic [15:0]              loop_end = '0;
  logic [23:0]              step = '0;
  logic [15:0]              length_frames = '0;
  logic                     done;
  logic signed [lsvm_pkg::MIX_W-1:0] mix_sample;

  mix_scoreboard board;
  int                       cycles = 0;
  int                       sent = 0;
  bit                       quiet = 1'b0;
  logic [15:0]              hot_base;

  looping_sample_voice_mixer dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .voice         (voice),
    .address       (address),
    .sample_value  (sample_value),
    .loop_start    (loop_start),
    .loop_end      (loop_end),
    .step          (step),
    .length_frames (length_frames),
    .done          (done),
    .mix_sample    (mix_sample)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL looping_sample_voice_mixer");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_mix(mix_sample);
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic idle_gap();
    int r, n;
    if (quiet) return;
    r = $urandom_range(0, 99);
    if (r < 60) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else if (r < 98) n = $urandom_range(4, 20);
    else n = $urandom_range(30, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(lsvm_pkg::func_t f, logic [3:0] v, logic [15:0] addr,
                           logic [15:0] value, logic [15:0] ls, logic [15:0] le,
                           logic [23:0] st, logic [15:0] len);
    idle_gap();
    func          <= f;
    voice         <= v;
    address       <= addr;
    sample_value  <= value;
    loop_start    <= ls;
    loop_end      <= le;
    step          <= st;
    length_frames <= len;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(f, v, addr, value, ls, le, st, len);
    sent++;
  endtask

  task automatic write_word(logic [15:0] addr, logic [15:0] value);
    send_item(lsvm_pkg::FUNC_WRITE, 4'($urandom), addr, value, 16'($urandom), 16'($urandom),
              24'($urandom), 16'($urandom));
  endtask

  task automatic launch_voice(logic [3:0] v, logic [15:0] addr, logic [15:0] ls,
                              logic [15:0] le, logic [23:0] st, logic [15:0] len);
    send_item(lsvm_pkg::FUNC_START, v, addr, 16'($urandom), ls, le, st, len);
  endtask

  // fill any unwritten word a sounding voice is about to read, then send a tick
  task automatic tick();
    for (int v = 0; v < lsvm_pkg::VOICES; v++) begin
      if (board.frames_left[v] != 0 && !board.written[board.position[v]])
        write_word(board.position[v], pick_value());
    end
    send_item(lsvm_pkg::FUNC_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 24'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.expected_mix.size() != 0);
  endtask

  task automatic random_start();
    logic [15:0] addr, ls, le, len;
    logic [23:0] st;
    int r;
    addr = ($urandom_range(0, 9) == 0) ? 16'($urandom) : hot_base + 16'($urandom_range(0, 255));
    r = $urandom_range(0, 9);
    if (r < 6) begin
      ls = addr - 16'($urandom_range(0, 32));
      le = addr + 16'($urandom_range(1, 64));
    end else if (r < 8) begin
      ls = addr + 16'($urandom_range(0, 40));
      le = addr - 16'($urandom_range(0, 40));
    end else begin
      ls = 16'($urandom);
      le = 16'($urandom);
    end
    r = $urandom_range(0, 19);
    if (r == 0) st = '0;
    else if (r == 1) st = 24'hFFFFFF;
    else if (r < 4) st = 24'($urandom);
    else if (r < 8) st = 24'($urandom_range(0, 24'h040000));
    else st = 24'($urandom_range(0, 24'h01FFFF));
    r = $urandom_range(0, 19);
    if (r < 4) len = '0;
    else if (r < 14) len = 16'($urandom_range(1, 3));
    else if (r < 19) len = 16'($urandom_range(4, 12));
    else len = 16'($urandom);
    launch_voice(4'($urandom_range(0, 15)), addr, ls, le, st, len);
  endtask

  initial begin
    int r;
    int i;
    board = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    hot_base = 16'($urandom);

    write_word(16'h0000, 16'h8000);
    write_word(16'hFFFF, 16'h7FFF);
    write_word(16'h0001, 16'h0001);
    tick();
    send_item(lsvm_pkg::FUNC_NONE, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF,
              16'hFFFF);
    launch_voice(4'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 24'h010000, 16'd1);
    launch_voice(4'd15, 16'h0000, 16'h0002, 16'h0001, 24'hFFFFFF, 16'hFFFF);
    launch_voice(4'd7, 16'h0001, 16'h0000, 16'h0000, 24'h000000, 16'd0);
    tick();
    tick();
    // restart voice 0 while it sounds
    launch_voice(4'd0, 16'h0001, 16'h0000, 16'h0003, 24'h008000, 16'd2);
    tick();
    tick();
    tick();
    launch_voice(4'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'h000000, 16'd1);
    launch_voice(4'd2, 16'h0000, 16'h0000, 16'h0000, 24'h000001, 16'd1);
    tick();
    tick();
    drain();

    i = 0;
    while (sent < 700) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == 200) drain();
      r = $urandom_range(0, 99);
      if (r < 14)
        write_word(($urandom_range(0, 4) == 0) ? 16'($urandom)
                                               : hot_base + 16'($urandom_range(0, 255)),
                   pick_value());
      else if (r < 30)
        random_start();
      else if (r < 33)
        send_item(lsvm_pkg::FUNC_NONE, 4'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 24'($urandom), 16'($urandom));
      else
        tick();
      i++;
    end

    start <= 1'b0;
    while (board.expected_mix.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Run covered %0d sample writes, %0d voice starts, %0d ticks, %0d unused codes.",
             board.writes, board.starts, board.ticks, board.idles);
    $display("Mixes checked %0d, loop wraps %0d, voices run out %0d, mismatches %0d.",
             board.checked, board.wraps, board.expiries, board.errors);
    if (board.errors == 0 && board.expected_mix.size() == 0) begin
      $display("PASS looping_sample_voice_mixer");
    end else begin
      $display("FAIL looping_sample_voice_mixer");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/lsvm_pkg.sv
rtl/lsvm_ctrl.sv
rtl/lsvm_datapath.sv
rtl/looping_sample_voice_mixer.sv
verif/looping_sample_voice_mixer_tb.sv
